/* design/dsms_pkg.sv */
// ----------------------------------------------------------------------------
// dsms_pkg
// Types and constants for the dynamic sequence max-subarray core.
// ----------------------------------------------------------------------------
package dsms_pkg;

    localparam int POS_W     = 9;
    localparam int VAL_W     = 16;
    localparam int SUM_OUT_W = 24;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_REPLACE = 2'd2,
        OP_QUERY   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RUN,
        S_PUT,
        S_RESP
    } t_state;

    typedef struct packed {
        t_op                     opcode;
        logic [POS_W-1:0]        position;
        logic [POS_W-1:0]        right_position;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [SUM_OUT_W-1:0] max_sum;
        t_status                     status;
    } t_rsp;

    typedef struct packed {
        logic init;
        logic step;
    } t_kctl;

endpackage

/* design/dsms_ram.sv */
// ----------------------------------------------------------------------------
// dsms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/dsms_kadane.sv */
// ----------------------------------------------------------------------------
// dsms_kadane
// Running-sum unit: one add and one compare per element scanned.
// ----------------------------------------------------------------------------
module dsms_kadane import dsms_pkg::*; #(
    parameter int VALUE_BITS = 16,
    parameter int SUM_W      = 25
) (
    input  logic                         i_clk,
    input  t_kctl                        i_ctl,
    input  logic signed [VALUE_BITS-1:0] i_x,
    output logic signed [SUM_W-1:0]      o_best
);

    logic signed [SUM_W-1:0] r_cur;
    logic signed [SUM_W-1:0] r_best;
    logic signed [SUM_W-1:0] n_cur;
    logic signed [SUM_W-1:0] n_best;
    logic signed [SUM_W-1:0] x_ext;
    logic                    cur_pos;

    assign x_ext   = SUM_W'(i_x);
    assign cur_pos = !r_cur[SUM_W-1] && (r_cur != '0);

    always_comb begin
        n_cur  = r_cur;
        n_best = r_best;
        if (i_ctl.init) begin
            n_cur  = x_ext;
            n_best = x_ext;
        end else if (i_ctl.step) begin
            n_cur  = cur_pos ? r_cur + x_ext : x_ext;
            n_best = (n_cur > r_best) ? n_cur : r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_best <= n_best;
    end

    assign o_best = r_best;

endmodule

/* design/dsms_ctrl.sv */
// ----------------------------------------------------------------------------
// dsms_ctrl
// Sequencer: checks each transaction, walks the store one entry per cycle to
// shift or scan it, and issues the result strobe.
// ----------------------------------------------------------------------------
module dsms_ctrl import dsms_pkg::*; #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 16,
    localparam int AW        = $clog2(CAPACITY)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_cmd                  i_cmd,
    output logic                  o_busy,
    output logic                  o_done,
    output t_status               o_status,
    output logic                  o_sum_sel,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [VALUE_BITS-1:0] o_wr_data,
    output logic [AW-1:0]         o_rd_addr,
    input  logic [VALUE_BITS-1:0] i_rd_data,
    output t_kctl                 o_kctl
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int PW    = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int RAW_W = (VALUE_BITS > VAL_W) ? VALUE_BITS : VAL_W;

    t_state          r_state,     n_state;
    t_cmd            r_cmd,       n_cmd;
    logic [CW-1:0]   r_count,     n_count;
    logic [AW-1:0]   r_rd_addr,   n_rd_addr;
    logic [AW-1:0]   r_last,      n_last;
    logic            r_dir_dn,    n_dir_dn;
    logic            r_rd_done,   n_rd_done;
    logic            r_pend,      n_pend;
    logic [AW-1:0]   r_pend_addr, n_pend_addr;
    logic            r_first,     n_first;
    t_status         r_status,    n_status;
    logic            r_sum_sel,   n_sum_sel;
    logic            r_done,      n_done;

    logic [PW-1:0]         pos_x;
    logic [PW-1:0]         rpos_x;
    logic [PW-1:0]         cnt_x;
    logic [AW-1:0]         at;
    logic [RAW_W-1:0]      raw;
    logic [VALUE_BITS-1:0] elem;
    logic                  full;
    logic                  pos_zero;

    assign pos_x    = PW'(r_cmd.position);
    assign rpos_x   = PW'(r_cmd.right_position);
    assign cnt_x    = PW'(r_count);
    assign at       = AW'(pos_x - PW'(1));
    assign raw      = RAW_W'($unsigned(r_cmd.value));
    assign elem     = raw[VALUE_BITS-1:0];
    assign full     = (cnt_x >= PW'(CAPACITY));
    assign pos_zero = (pos_x == '0);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_rd_addr   = r_rd_addr;
        n_last      = r_last;
        n_dir_dn    = r_dir_dn;
        n_rd_done   = r_rd_done;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_first     = r_first;
        n_status    = r_status;
        n_sum_sel   = r_sum_sel;
        n_done      = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_pend_addr;
        o_wr_data   = i_rd_data;
        o_rd_addr   = r_rd_addr;
        o_kctl      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status  = ST_OK;
                n_sum_sel = 1'b0;
                n_rd_done = 1'b0;
                n_pend    = 1'b0;
                n_first   = 1'b1;
                n_state   = S_RESP;
                case (r_cmd.opcode)
                    OP_INSERT: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else if (pos_zero || pos_x > cnt_x + PW'(1)) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            n_count = r_count + CW'(1);
                            if (pos_x == cnt_x + PW'(1)) begin
                                n_state = S_PUT;
                            end else begin
                                n_rd_addr = AW'(cnt_x - PW'(1));
                                n_last    = at;
                                n_dir_dn  = 1'b1;
                                n_state   = S_RUN;
                            end
                        end
                    end
                    OP_DELETE: begin
                        if (pos_zero || pos_x > cnt_x) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            n_count = r_count - CW'(1);
                            if (pos_x != cnt_x) begin
                                n_rd_addr = at + AW'(1);
                                n_last    = AW'(cnt_x - PW'(1));
                                n_dir_dn  = 1'b0;
                                n_state   = S_RUN;
                            end
                        end
                    end
                    OP_REPLACE: begin
                        if (pos_zero || pos_x > cnt_x) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = at;
                            o_wr_data = elem;
                        end
                    end
                    OP_QUERY: begin
                        if (pos_zero || pos_x > rpos_x || rpos_x > cnt_x) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            n_rd_addr = at;
                            n_last    = AW'(rpos_x - PW'(1));
                            n_dir_dn  = 1'b0;
                            n_sum_sel = 1'b1;
                            n_state   = S_RUN;
                        end
                    end
                    default: begin
                        n_status = ST_BAD_POS;
                    end
                endcase
            end
            S_RUN: begin
                if (!r_rd_done) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_dir_dn ? r_rd_addr + AW'(1) : r_rd_addr - AW'(1);
                    if (r_rd_addr == r_last) begin
                        n_rd_done = 1'b1;
                    end else begin
                        n_rd_addr = r_dir_dn ? r_rd_addr - AW'(1) : r_rd_addr + AW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_cmd.opcode == OP_QUERY) begin
                        o_kctl.init = r_first;
                        o_kctl.step = !r_first;
                        n_first     = 1'b0;
                    end else begin
                        o_wr_en = 1'b1;
                    end
                end
                if (r_rd_done && !r_pend) begin
                    n_state = (r_cmd.opcode == OP_INSERT) ? S_PUT : S_RESP;
                end
            end
            S_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = at;
                o_wr_data = elem;
                n_state   = S_RESP;
            end
            S_RESP: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_done <= 1'b0;
            r_pend    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_done <= n_rd_done;
            r_pend    <= n_pend;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_rd_addr   <= n_rd_addr;
        r_last      <= n_last;
        r_dir_dn    <= n_dir_dn;
        r_pend_addr <= n_pend_addr;
        r_first     <= n_first;
        r_status    <= n_status;
        r_sum_sel   <= n_sum_sel;
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_status  = r_status;
    assign o_sum_sel = r_sum_sel;

endmodule

/* design/dynamic_sequence_max_subarray_core.sv */
// ----------------------------------------------------------------------------
// dynamic_sequence_max_subarray_core
// Ordered store of signed values with insert, delete, replace and
// range max-subarray query.
// ----------------------------------------------------------------------------
// A transaction is checked in the execute state, where a replace also writes
// its value; shifts and scans walk the store in the run state, an insert
// writes its value in the put state, and the result strobe follows the
// response state. One transaction is in flight at a time. The RAM, with one
// read and one write port, moves or scans one entry per cycle; busy stays high
// until the strobe, and a new transaction is taken in the strobe cycle.
// Synchronous active-low reset empties the store and drops any work.
// ----------------------------------------------------------------------------
module dynamic_sequence_max_subarray_core import dsms_pkg::*; #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_cmd i_cmd,
    output logic o_valid,
    output t_rsp o_rsp
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int SUM_W = VALUE_BITS + $clog2(CAPACITY) + 1;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [VALUE_BITS-1:0]   wr_data;
    logic [AW-1:0]           rd_addr;
    logic [VALUE_BITS-1:0]   rd_data;
    t_kctl                   kctl;
    logic signed [SUM_W-1:0] best;
    t_status                 status;
    logic                    sum_sel;

    dsms_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    dsms_ctrl #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cmd     (i_cmd),
        .o_busy    (busy),
        .o_done    (o_valid),
        .o_status  (status),
        .o_sum_sel (sum_sel),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_kctl    (kctl)
    );

    dsms_kadane #(
        .VALUE_BITS (VALUE_BITS),
        .SUM_W      (SUM_W)
    ) u_kadane (
        .i_clk  (i_clk),
        .i_ctl  (kctl),
        .i_x    ($signed(rd_data)),
        .o_best (best)
    );

    assign o_rsp.status  = status;
    assign o_rsp.max_sum = (sum_sel && status == ST_OK) ? SUM_OUT_W'(best) : '0;

endmodule

/* design/dsms_checker.sv */
// ----------------------------------------------------------------------------
// dsms_checker
// Port-level checks for the dynamic sequence max-subarray core.
// ----------------------------------------------------------------------------
module dsms_checker import dsms_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input t_rsp o_rsp
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted transaction");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("transaction ended without a result");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status != ST_OK |-> o_rsp.max_sum == '0)
        else $error("nonzero sum on a rejected transaction");

endmodule

bind dynamic_sequence_max_subarray_core dsms_checker u_dsms_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);
